// ===== sv/y420m_pkg.sv =====
`timescale 1ns / 1ps

package y420m_pkg;

    // request kinds
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // plane codes
    localparam logic [1:0] PLANE_Y = 2'd0;
    localparam logic [1:0] PLANE_U = 2'd1;
    localparam logic [1:0] PLANE_V = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    // row counter and row limit widths
    localparam int ROW_W  = 12;
    localparam int ROWS_W = 13;
    localparam logic [ROWS_W-1:0] MAX_ROWS   = 13'd4096;
    localparam logic [ROWS_W-1:0] RST_ROWS   = 13'd480;
    localparam int               RST_WIDTH  = 640;

    // what one accepted item emits: up to two bytes of the pending line
    typedef struct packed {
        logic [1:0] count;
        logic [1:0] plane;
        logic       line_end0;
        logic       line_end1;
        logic       frame_last;
    } t_emit;

endpackage

// ===== sv/y420m_store.sv =====
`timescale 1ns / 1ps

module y420m_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr0,
    input  logic [AW-1:0] i_rd_addr1,
    output logic [7:0]    o_pix0,
    output logic [7:0]    o_pix1
);

    logic [7:0] mem [DEPTH];

    logic [7:0] r_rd0;
    logic [7:0] r_rd1;
    logic [7:0] r_wdata;
    logic       r_fwd0;
    logic       r_fwd1;

    // write the incoming byte
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read both bytes, note a same-cycle write to either address
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd0   <= mem[i_rd_addr0];
            r_rd1   <= mem[i_rd_addr1];
            r_wdata <= i_wr_data;
            r_fwd0  <= i_wr_en && (i_wr_addr == i_rd_addr0);
            r_fwd1  <= i_wr_en && (i_wr_addr == i_rd_addr1);
        end
    end

    // forward the written byte over stale read data
    assign o_pix0 = r_fwd0 ? r_wdata : r_rd0;
    assign o_pix1 = r_fwd1 ? r_wdata : r_rd1;

endmodule

// ===== sv/y420m_ctrl.sv =====
`timescale 1ns / 1ps

module y420m_ctrl
    import y420m_pkg::*;
#(
    parameter int MAX_LINE = 2048,
    parameter int CW       = 11,
    parameter int AW       = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_req_type,
    input  logic [7:0]            i_pixel_in,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output logic [7:0]            o_wr_data,
    output logic [AW-1:0]         o_rd_addr0,
    output logic [AW-1:0]         o_rd_addr1,
    output t_emit                 o_emit
);

    localparam int LEN_W   = CW + 1;
    localparam int LIM     = MAX_LINE & ~1;
    localparam int RST_LEN = (LIM < RST_WIDTH) ? LIM : RST_WIDTH;

    function automatic logic [AW-1:0] bank_addr(input logic bank, input logic [CW-1:0] idx);
        logic [AW-1:0] base;
        base = bank ? AW'(MAX_LINE) : '0;
        return base + AW'(idx);
    endfunction

    logic [LEN_W-1:0]  r_len_y;
    logic [ROWS_W-1:0] r_rows_y;
    logic [CW-1:0]     r_col;
    logic [ROW_W-1:0]  r_row;
    logic [1:0]        r_plane;
    logic              r_bank;
    logic [LEN_W-1:0]  r_pend;
    logic [1:0]        r_pend_plane;
    logic              r_pend_last;

    logic [LEN_W-1:0]  n_len_y;
    logic [ROWS_W-1:0] n_rows_y;
    logic [CW-1:0]     n_col;
    logic [ROW_W-1:0]  n_row;
    logic [1:0]        n_plane;
    logic              n_bank;
    logic [LEN_W-1:0]  n_pend;
    logic [1:0]        n_pend_plane;
    logic              n_pend_last;

    logic [11:0]       cfg_w;
    logic [ROWS_W-1:0] cfg_h;
    logic [LEN_W-1:0]  line_len;
    logic [ROWS_W-1:0] plane_rows;
    logic [LEN_W-1:0]  col_inc;
    logic [ROWS_W-1:0] row_inc;
    logic              last_row;
    logic              complete;
    logic              frame_last;
    logic [LEN_W-1:0]  pend_now;
    logic [1:0]        count;
    logic              rd_bank;

    // clamp configuration to even, legal sizes
    always_comb begin
        cfg_w    = {i_cfg_data[11:1], 1'b0};
        cfg_h    = {i_cfg_data[12:1], 1'b0};
        n_len_y  = r_len_y;
        n_rows_y = r_rows_y;
        if (i_cfg_we && (i_cfg_index == CFG_WIDTH)) begin
            if (cfg_w < 12'd2) begin
                n_len_y = LEN_W'(2);
            end else if (int'(cfg_w) > LIM) begin
                n_len_y = LEN_W'(LIM);
            end else begin
                n_len_y = LEN_W'(cfg_w);
            end
        end
        if (i_cfg_we && (i_cfg_index == CFG_HEIGHT)) begin
            if (cfg_h < ROWS_W'(2)) begin
                n_rows_y = ROWS_W'(2);
            end else if (cfg_h > MAX_ROWS) begin
                n_rows_y = MAX_ROWS;
            end else begin
                n_rows_y = cfg_h;
            end
        end
    end

    // line geometry of the plane being written
    assign line_len   = (r_plane == PLANE_Y) ? r_len_y : (r_len_y >> 1);
    assign plane_rows = (r_plane == PLANE_Y) ? r_rows_y : (r_rows_y >> 1);
    assign col_inc    = {1'b0, r_col} + LEN_W'(1);
    assign row_inc    = {1'b0, r_row} + ROWS_W'(1);
    assign last_row   = row_inc >= plane_rows;
    assign complete   = (i_req_type == REQ_PIXEL) && (col_inc >= line_len);
    assign frame_last = (r_plane == PLANE_V) && last_row;

    // pending line as seen after this item's write
    assign pend_now = complete ? col_inc : r_pend;
    assign count    = (pend_now >= LEN_W'(2)) ? 2'd2 : pend_now[1:0];
    assign rd_bank  = complete ? r_bank : ~r_bank;

    // advance write position and pending line
    always_comb begin
        n_col        = r_col;
        n_row        = r_row;
        n_plane      = r_plane;
        n_bank       = r_bank;
        n_pend       = r_pend;
        n_pend_plane = r_pend_plane;
        n_pend_last  = r_pend_last;
        if (i_accept) begin
            if (complete) begin
                n_pend_plane = r_plane;
                n_pend_last  = frame_last;
                n_bank       = ~r_bank;
                n_col        = '0;
                if (last_row) begin
                    n_row = '0;
                    case (r_plane)
                        PLANE_Y: n_plane = PLANE_U;
                        PLANE_U: n_plane = PLANE_V;
                        default: n_plane = PLANE_Y;
                    endcase
                end else begin
                    n_row = row_inc[ROW_W-1:0];
                end
            end else if (i_req_type == REQ_PIXEL) begin
                n_col = col_inc[CW-1:0];
            end
            n_pend = pend_now - LEN_W'(count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_y      <= LEN_W'(RST_LEN);
            r_rows_y     <= RST_ROWS;
            r_col        <= '0;
            r_row        <= '0;
            r_plane      <= PLANE_Y;
            r_bank       <= 1'b0;
            r_pend       <= '0;
            r_pend_plane <= PLANE_Y;
            r_pend_last  <= 1'b0;
        end else begin
            r_len_y      <= n_len_y;
            r_rows_y     <= n_rows_y;
            r_col        <= n_col;
            r_row        <= n_row;
            r_plane      <= n_plane;
            r_bank       <= n_bank;
            r_pend       <= n_pend;
            r_pend_plane <= n_pend_plane;
            r_pend_last  <= n_pend_last;
        end
    end

    // store accesses and what this item emits
    assign o_wr_en    = i_accept && (i_req_type == REQ_PIXEL);
    assign o_wr_addr  = bank_addr(r_bank, r_col);
    assign o_wr_data  = i_pixel_in;
    assign o_rd_addr0 = bank_addr(rd_bank, CW'(pend_now - LEN_W'(1)));
    assign o_rd_addr1 = bank_addr(rd_bank, CW'(pend_now - LEN_W'(2)));

    assign o_emit.count      = count;
    assign o_emit.plane      = complete ? r_plane : r_pend_plane;
    assign o_emit.line_end0  = pend_now == LEN_W'(1);
    assign o_emit.line_end1  = pend_now == LEN_W'(2);
    assign o_emit.frame_last = complete ? frame_last : r_pend_last;

endmodule

// ===== sv/y420m_out.sv =====
`timescale 1ns / 1ps

module y420m_out
    import y420m_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_emit      i_emit,
    input  logic [7:0] i_pix0,
    input  logic [7:0] i_pix1,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_pixel_out,
    output logic [1:0] o_plane_id,
    output logic       o_line_end,
    output logic       o_frame_end,
    output logic       o_step_last
);

    logic       r_a_valid;
    t_emit      r_a_emit;
    logic       r_b_valid;
    logic       r_b_sel;
    t_emit      r_b_emit;
    logic [7:0] r_b_px0;
    logic [7:0] r_b_px1;

    logic       out_take;
    logic       b_last;
    logic       b_free;
    logic       a_move;

    // hand off between read stage and output stage
    assign b_last   = r_b_sel || (r_b_emit.count == 2'd1);
    assign out_take = r_b_valid && !i_stall;
    assign b_free   = !r_b_valid || (out_take && b_last);
    assign a_move   = r_a_valid && ((r_a_emit.count == 2'd0) || b_free);
    assign o_ready  = !r_a_valid || a_move;

    // hold the emit info while the store read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_accept) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_emit <= i_emit;
        end
    end

    // step through the one or two bytes of an item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_sel   <= 1'b0;
        end else if (a_move && (r_a_emit.count != 2'd0)) begin
            r_b_valid <= 1'b1;
            r_b_sel   <= 1'b0;
        end else if (out_take) begin
            if (b_last) begin
                r_b_valid <= 1'b0;
            end else begin
                r_b_sel <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move && (r_a_emit.count != 2'd0)) begin
            r_b_emit <= r_a_emit;
            r_b_px0  <= i_pix0;
            r_b_px1  <= i_pix1;
        end
    end

    assign o_valid     = r_b_valid;
    assign o_pixel_out = r_b_sel ? r_b_px1 : r_b_px0;
    assign o_plane_id  = r_b_emit.plane;
    assign o_line_end  = r_b_sel ? r_b_emit.line_end1 : r_b_emit.line_end0;
    assign o_frame_end = o_line_end && r_b_emit.frame_last;
    assign o_step_last = b_last;

endmodule

// ===== sv/yuv420_horizontal_mirror_unit.sv =====
`timescale 1ns / 1ps
// Path: an accepted item's emit info and store read are registered in the read stage,
// then move into the output stage, which drives the output; a stall can hold either stage.
// Throughput, while i_stall is low: one item per cycle while items emit at most one byte;
// an item that emits two bytes holds the single output register, one byte per cycle.
// Reset: clears write position, plane, bank and pending count, and loads width 640 and
// height 480; the line store is not cleared and holds nothing valid until written.

module yuv420_horizontal_mirror_unit
    import y420m_pkg::*;
#(
    parameter int MAX_LINE = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_req_type,
    input  logic [7:0]            i_pixel_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_pixel_out,
    output logic [1:0]            o_plane_id,
    output logic                  o_line_end,
    output logic                  o_frame_end,
    output logic                  o_step_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW    = $clog2(MAX_LINE);
    localparam int DEPTH = 2 * MAX_LINE;
    localparam int AW    = $clog2(DEPTH);

    logic          accept;
    logic          ready;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr0;
    logic [AW-1:0] rd_addr1;
    logic [7:0]    pix0;
    logic [7:0]    pix1;
    t_emit         emit;

    assign accept  = i_valid && ready;
    assign o_stall = !ready;

    y420m_ctrl #(
        .MAX_LINE (MAX_LINE),
        .CW       (CW),
        .AW       (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req_type  (i_req_type),
        .i_pixel_in  (i_pixel_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr0  (rd_addr0),
        .o_rd_addr1  (rd_addr1),
        .o_emit      (emit)
    );

    y420m_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_rd_en    (accept),
        .i_rd_addr0 (rd_addr0),
        .i_rd_addr1 (rd_addr1),
        .o_pix0     (pix0),
        .o_pix1     (pix1)
    );

    y420m_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_emit      (emit),
        .i_pix0      (pix0),
        .i_pix1      (pix1),
        .o_ready     (ready),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel_out (o_pixel_out),
        .o_plane_id  (o_plane_id),
        .o_line_end  (o_line_end),
        .o_frame_end (o_frame_end),
        .o_step_last (o_step_last)
    );

endmodule
